/* src/feature_distance_ratio_unit_assert.svh */
// Assertion helpers shared by the distance/ratio block.
// Both forms sample on clk and are held off while rst_n is low.
`ifndef FEATURE_DISTANCE_RATIO_UNIT_ASSERT_SVH
`define FEATURE_DISTANCE_RATIO_UNIT_ASSERT_SVH

// Same-cycle implication
`define FDR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdr assertion failed: same-cycle implication");

// Next-cycle implication
`define FDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdr assertion failed: next-cycle implication");

`endif

/* src/fdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fdr_pkg;

    // Mode register codes
    localparam logic [1:0] MODE_SSD   = 2'd0;
    localparam logic [1:0] MODE_SAD   = 2'd1;
    localparam logic [1:0] MODE_DIST  = 2'd2;
    localparam logic [1:0] MODE_RATIO = 2'd3;

    localparam int ACC_W      = 39;
    localparam int SRC_W      = 40;
    localparam int REM_W      = 24;
    localparam int QUO_W      = 32;
    localparam int ROOT_W     = 20;
    localparam int CNT_W      = 6;
    localparam int OUT_W      = 48;

    localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(ROOT_W);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(QUO_W);

    localparam logic [OUT_W-1:0] Q16_ONE = OUT_W'(65536);

    // Vector sum handed from the accumulator to the sequencer
    typedef struct packed {
        logic             fin;
        logic [ACC_W-1:0] sum;
    } acc_out_t;

    // Launch command for the shared shift/subtract unit
    typedef struct packed {
        logic             start;
        logic             is_sqrt;
        logic [SRC_W-1:0] src;
        logic [15:0]      divisor;
    } iter_cmd_t;

    // Completion status of the shared unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } iter_stat_t;

endpackage

`default_nettype wire

/* src/fdr_accum.sv */
`timescale 1ns / 1ps
`default_nettype none

module fdr_accum (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic signed [15:0]  element_a,
    input  wire logic signed [15:0]  element_b,
    input  wire logic                last_element,
    input  wire logic [1:0]          mode,
    output fdr_pkg::acc_out_t        acc_out
);
    import fdr_pkg::*;

    logic              v1_reg;
    logic              last1_reg;
    logic [15:0]       ad1_reg;
    logic              v2_reg;
    logic              last2_reg;
    logic [31:0]       term2_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;

    logic [16:0]       diff;
    logic [16:0]       absd;
    logic [31:0]       term;
    logic [ACC_W:0]    raw_sum;
    logic [ACC_W-1:0]  sat_sum;

    // Absolute difference of the pair
    always_comb
    begin
        diff = {element_a[15], element_a} - {element_b[15], element_b};
        absd = diff[16] ? (17'd0 - diff) : diff;
    end

    // Pick the term for the current mode
    always_comb
    begin
        case (mode)
            MODE_SSD, MODE_DIST: term = {16'd0, ad1_reg} * {16'd0, ad1_reg};
            MODE_SAD:            term = {16'd0, ad1_reg};
            default:             term = 32'd0;
        endcase
    end

    // Saturating add into the running sum
    always_comb
    begin
        raw_sum  = {1'b0, acc_reg} + {8'd0, term2_reg};
        sat_sum  = raw_sum[ACC_W] ? {ACC_W{1'b1}} : raw_sum[ACC_W-1:0];
        acc_next = acc_reg;
        if (v2_reg)
        begin
            acc_next = last2_reg ? '0 : sat_sum;
        end
    end

    assign acc_out.fin = v2_reg & last2_reg;
    assign acc_out.sum = sat_sum;

    // Advance the two stages and the sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            v1_reg    <= take;
            last1_reg <= take & last_element;
            v2_reg    <= v1_reg;
            last2_reg <= v1_reg & last1_reg;
            acc_reg   <= acc_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        ad1_reg   <= absd[15:0];
        term2_reg <= term;
    end

endmodule

`default_nettype wire

/* src/fdr_iter.sv */
`timescale 1ns / 1ps
`default_nettype none

module fdr_iter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fdr_pkg::iter_cmd_t cmd,
    output fdr_pkg::iter_stat_t  stat
);
    import fdr_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic              sqrt_reg;
    logic              sqrt_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [SRC_W-1:0]  src_reg;
    logic [SRC_W-1:0]  src_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [QUO_W-1:0]  q_reg;
    logic [QUO_W-1:0]  q_next;
    logic [15:0]       div_reg;
    logic [15:0]       div_next;

    logic [REM_W-1:0]  lhs;
    logic [REM_W-1:0]  rhs;
    logic [REM_W:0]    diff;
    logic              fits;

    // One shift/subtract step: two source bits for root, one for divide
    always_comb
    begin
        if (sqrt_reg)
        begin
            lhs = {rem_reg[REM_W-3:0], src_reg[SRC_W-1 -: 2]};
            rhs = {2'b00, q_reg[ROOT_W-1:0], 2'b01};
        end
        else
        begin
            lhs = {rem_reg[REM_W-2:0], src_reg[SRC_W-1]};
            rhs = {8'd0, div_reg};
        end
        diff = {1'b0, lhs} - {1'b0, rhs};
        fits = ~diff[REM_W];
    end

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sqrt_next = sqrt_reg;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            sqrt_next = cmd.is_sqrt;
            cnt_next  = cmd.is_sqrt ? SQRT_STEPS : DIV_STEPS;
            src_next  = cmd.src;
            rem_next  = '0;
            q_next    = '0;
            div_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[REM_W-1:0] : lhs;
            q_next   = {q_reg[QUO_W-2:0], fits};
            src_next = sqrt_reg ? {src_reg[SRC_W-3:0], 2'b00} : {src_reg[SRC_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quo  = q_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        div_reg  <= div_next;
    end

endmodule

`default_nettype wire

/* src/feature_distance_ratio_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Transaction carries
// s_axis    in         tdata {element_b, element_a}, tlast last_element
// m_axis    out        tdata value (48 b), tuser divide_by_zero
// cfg       in         cfg_data mode (2 b), always ready
//
// Element pairs are taken one per cycle until the pair marked tlast.
// After that pair tready stays low while the sum leaves the accumulator and, for
// the distance (20 root steps of the shared shift/subtract unit) and for a ratio of
// unequal values with a nonzero divisor (32 divide steps), while that unit runs,
// until the result sits in the output register. A result still waiting there holds
// the next vector's result back and keeps tready low until it is taken.
// rst_n clears mode and the running sum and sets the first-pair flag.

`include "feature_distance_ratio_unit_assert.svh"

module feature_distance_ratio_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] element_a, [31:16] element_b
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [47:0] value
    output logic             m_axis_tuser,   // [0] divide_by_zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data
);
    import fdr_pkg::*;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [1:0]        mode_reg;
    logic              at_first_reg;
    logic              at_first_next;
    logic signed [15:0] first_a_reg;
    logic signed [15:0] first_b_reg;
    logic              neg_reg;
    logic              neg_next;
    logic [OUT_W-1:0]  res_reg;
    logic [OUT_W-1:0]  res_next;
    logic              dz_reg;
    logic              dz_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_dz_reg;
    logic              out_load;

    logic              in_take;
    acc_out_t          acc_out;
    iter_cmd_t         cmd;
    iter_stat_t        stat;

    logic signed [15:0] small_v;
    logic signed [15:0] large_v;
    logic [16:0]       abs_small;
    logic [16:0]       abs_large;
    logic [OUT_W-1:0]  quo_ext;

    assign in_take       = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (state_reg == ST_RUN);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_dz_reg;

    fdr_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (in_take),
        .element_a    (s_axis_tdata[15:0]),
        .element_b    (s_axis_tdata[31:16]),
        .last_element (s_axis_tlast),
        .mode         (mode_reg),
        .acc_out      (acc_out)
    );

    fdr_iter u_iter (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .stat (stat)
    );

    // Order the first pair for the ratio
    always_comb
    begin
        if (first_a_reg < first_b_reg)
        begin
            small_v = first_a_reg;
            large_v = first_b_reg;
        end
        else
        begin
            small_v = first_b_reg;
            large_v = first_a_reg;
        end
        abs_small = small_v[15] ? (17'd0 - {1'b1, small_v}) : {1'b0, small_v};
        abs_large = large_v[15] ? (17'd0 - {1'b1, large_v}) : {1'b0, large_v};
        quo_ext   = {16'd0, stat.quo};
    end

    // Sequencer: collect, launch the shared unit, stage the result
    always_comb
    begin
        state_next    = state_reg;
        at_first_next = at_first_reg;
        neg_next      = neg_reg;
        res_next      = res_reg;
        dz_next       = dz_reg;
        out_load      = 1'b0;
        cmd.start     = 1'b0;
        cmd.is_sqrt   = 1'b0;
        cmd.src       = '0;
        cmd.divisor   = '0;
        case (state_reg)
            ST_RUN:
            begin
                if (in_take)
                begin
                    at_first_next = s_axis_tlast;
                    if (s_axis_tlast)
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                if (acc_out.fin)
                begin
                    dz_next = 1'b0;
                    case (mode_reg)
                        MODE_DIST:
                        begin
                            cmd.start   = 1'b1;
                            cmd.is_sqrt = 1'b1;
                            cmd.src     = {1'b0, acc_out.sum};
                            state_next  = ST_CALC;
                        end
                        MODE_RATIO:
                        begin
                            if (first_a_reg == first_b_reg)
                            begin
                                res_next   = Q16_ONE;
                                state_next = ST_LOAD;
                            end
                            else if (large_v == 16'sd0)
                            begin
                                res_next   = '0;
                                dz_next    = 1'b1;
                                state_next = ST_LOAD;
                            end
                            else
                            begin
                                cmd.start   = 1'b1;
                                cmd.src     = {abs_small[15:0], 24'd0};
                                cmd.divisor = abs_large[15:0];
                                neg_next    = small_v[15] ^ large_v[15];
                                state_next  = ST_CALC;
                            end
                        end
                        default:
                        begin
                            res_next   = {{(OUT_W-ACC_W){1'b0}}, acc_out.sum};
                            state_next = ST_LOAD;
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                if (stat.done)
                begin
                    if (mode_reg == MODE_DIST)
                    begin
                        res_next = {{(OUT_W-ROOT_W){1'b0}}, stat.quo[ROOT_W-1:0]};
                    end
                    else
                    begin
                        res_next = neg_reg ? (OUT_W'(0) - quo_ext) : quo_ext;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Output register: load a result or drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            mode_reg      <= MODE_SSD;
            at_first_reg  <= 1'b1;
            first_a_reg   <= '0;
            first_b_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            at_first_reg  <= at_first_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (in_take && at_first_reg)
            begin
                first_a_reg <= s_axis_tdata[15:0];
                first_b_reg <= s_axis_tdata[31:16];
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        res_reg <= res_next;
        dz_reg  <= dz_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
            out_dz_reg   <= dz_reg;
        end
    end

    `FDR_ASSERT_NEXT(a_last_stalls_input, in_take && s_axis_tlast, !s_axis_tready)
    `FDR_ASSERT_IMP(a_unit_busy_blocks_input, stat.busy, !s_axis_tready)
    `FDR_ASSERT_IMP(a_sum_only_while_waiting, acc_out.fin, state_reg == ST_WAIT)
    `FDR_ASSERT_IMP(a_dz_value_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 48'd0)

endmodule

`default_nettype wire
